// ----- design/sdspi_pkg.sv -----
package sdspi_pkg;

	// flush length and largest data block
	localparam logic [9:0] FLUSH_BYTES     = 10'd100;
	localparam logic [9:0] MAX_BLOCK_BYTES = 10'd512;

	// poll limit after reset
	localparam logic [7:0] POLL_LIMIT_RST = 8'd17;

	// frame and bus constants
	localparam logic [5:0] APP_CMD_INDEX = 6'd55;
	localparam logic [1:0] FRAME_START   = 2'b01;
	localparam logic [7:0] DATA_TOKEN    = 8'hFE;
	localparam logic [7:0] IDLE_BYTE     = 8'hFF;
	localparam logic [6:0] CRC7_POLY     = 7'h09;

	// transaction completion codes
	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_TIMEOUT    = 2'd1,
		ST_APP_REJECT = 2'd2,
		ST_R1_ERROR   = 2'd3
	} status_t;

	// fold one byte into a crc-7, msb first
	function automatic logic [6:0] crc7_byte(input logic [6:0] crc, input logic [7:0] data);
		logic [6:0] c;
		logic       fb;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = c[6] ^ data[i];
			c  = {c[5:0], 1'b0};
			if (fb) begin
				c = c ^ CRC7_POLY;
			end
		end
		return c;
	endfunction

endpackage

// ----- design/sd_spi_command_engine_core.sv -----
// sd card spi-mode command engine
// each accepted input word yields its result word from the result register in the next cycle
// throughput: one word per cycle; a stalled result holds off the input until it leaves
// the frame crc-7 is folded one byte per cycle from the start of a command until all five frame bytes are in
// reset (arst_n low, asynchronous): engine idle, result register empty, poll limit 17
module sd_spi_command_engine_core (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration
	input  logic                   cfg_wr_en,
	input  logic [7:0]             cfg_wr_data,
	// input channel
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   mode,
	input  logic [5:0]             cmd_index,
	input  logic [31:0]            argument,
	input  logic [2:0]             resp_bytes,
	input  logic                   app_prefix,
	input  logic [9:0]             data_len,
	input  logic [7:0]             miso_byte,
	// output channel
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   mosi_valid,
	output logic [7:0]             mosi_byte,
	output logic                   host_valid,
	output logic                   host_kind,
	output logic [7:0]             host_byte,
	output logic                   done_res,
	output sdspi_pkg::status_t     status
);
	import sdspi_pkg::*;

	typedef enum logic [7:0] {
		PH_IDLE  = 8'b0000_0001,
		PH_FLUSH = 8'b0000_0010,
		PH_FRAME = 8'b0000_0100,
		PH_POLL  = 8'b0000_1000,
		PH_RESP  = 8'b0001_0000,
		PH_TOKEN = 8'b0010_0000,
		PH_DATA  = 8'b0100_0000,
		PH_CRC   = 8'b1000_0000
	} phase_t;

	// state
	phase_t      phase_q, phase_d;
	logic [9:0]  cnt_q, cnt_d;
	logic [7:0]  poll_q, poll_d;
	logic [7:0]  poll_limit_q;
	logic        prefix_q, prefix_d;
	logic        r1nz_q, r1nz_d;
	logic [5:0]  req_cmd_q, req_cmd_d;
	logic [31:0] req_arg_q, req_arg_d;
	logic [2:0]  req_rlen_q, req_rlen_d;
	logic [9:0]  req_dlen_q, req_dlen_d;
	logic [5:0]  frm_cmd_q, frm_cmd_d;
	logic [31:0] frm_arg_q, frm_arg_d;

	// result register
	logic        out_valid_q;
	logic        mosi_valid_q, host_valid_q, host_kind_q, done_q;
	logic [7:0]  mosi_byte_q, host_byte_q;
	status_t     status_q;

	// next result
	logic        r_mosi_valid, r_host_valid, r_host_kind, r_done;
	logic [7:0]  r_mosi_byte, r_host_byte;
	status_t     r_status;

	// step helpers
	logic        in_fire;
	logic        emit, do_start, do_resp_done, do_finish;
	logic [5:0]  start_cmd;
	logic [31:0] start_arg;
	logic [7:0]  rd_r1;
	status_t     fin_status;
	logic [10:0] cnt_inc;
	logic [8:0]  poll_inc;
	logic [6:0]  crc;

	assign in_stall = out_valid_q & out_stall;
	assign in_fire  = in_valid & ~in_stall;
	assign cnt_inc  = {1'b0, cnt_q} + 11'd1;
	assign poll_inc = {1'b0, poll_q} + 9'd1;

	sdspi_crc7 u_crc7 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_fire & do_start),
		.frame  ({FRAME_START, start_cmd, start_arg}),
		.crc    (crc)
	);

	// one step of the engine per accepted word
	always_comb begin
		phase_d      = phase_q;
		cnt_d        = cnt_q;
		poll_d       = poll_q;
		prefix_d     = prefix_q;
		r1nz_d       = r1nz_q;
		req_cmd_d    = req_cmd_q;
		req_arg_d    = req_arg_q;
		req_rlen_d   = req_rlen_q;
		req_dlen_d   = req_dlen_q;
		frm_cmd_d    = frm_cmd_q;
		frm_arg_d    = frm_arg_q;
		r_mosi_valid = 1'b0;
		r_mosi_byte  = 8'd0;
		r_host_valid = 1'b0;
		r_host_kind  = 1'b0;
		r_host_byte  = 8'd0;
		r_done       = 1'b0;
		r_status     = ST_OK;
		emit         = 1'b0;
		do_start     = 1'b0;
		do_resp_done = 1'b0;
		do_finish    = 1'b0;
		start_cmd    = req_cmd_q;
		start_arg    = req_arg_q;
		rd_r1        = miso_byte;
		fin_status   = ST_OK;

		if (mode == 1'b0) begin
			// new request, drops whatever was running
			req_cmd_d = cmd_index;
			req_arg_d = argument;
			if (resp_bytes == 3'd0) begin
				req_rlen_d = 3'd1;
			end else if (resp_bytes > 3'd5) begin
				req_rlen_d = 3'd5;
			end else begin
				req_rlen_d = resp_bytes;
			end
			req_dlen_d = (data_len > MAX_BLOCK_BYTES) ? MAX_BLOCK_BYTES : data_len;
			prefix_d   = app_prefix;
			do_start   = 1'b1;
			start_cmd  = app_prefix ? APP_CMD_INDEX : cmd_index;
			start_arg  = app_prefix ? 32'd0 : argument;
			emit       = 1'b1;
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
				end
				PH_FLUSH: begin
					if (cnt_inc >= {1'b0, FLUSH_BYTES}) begin
						phase_d = PH_FRAME;
						cnt_d   = 10'd0;
					end else begin
						cnt_d = cnt_inc[9:0];
					end
					emit = 1'b1;
				end
				PH_FRAME: begin
					if (cnt_inc >= 11'd6) begin
						phase_d = PH_POLL;
						cnt_d   = 10'd0;
						poll_d  = 8'd0;
					end else begin
						cnt_d = cnt_inc[9:0];
					end
					emit = 1'b1;
				end
				PH_POLL: begin
					if (miso_byte[7] == 1'b0) begin
						r1nz_d = (miso_byte != 8'd0);
						if (!prefix_q && req_rlen_q > 3'd1) begin
							phase_d      = PH_RESP;
							cnt_d        = 10'd1;
							emit         = 1'b1;
							r_host_valid = 1'b1;
							r_host_byte  = miso_byte;
						end else begin
							do_resp_done = 1'b1;
							rd_r1        = miso_byte;
						end
					end else begin
						poll_d = poll_inc[7:0];
						if (poll_inc >= {1'b0, poll_limit_q}) begin
							do_finish  = 1'b1;
							fin_status = ST_TIMEOUT;
						end else begin
							emit = 1'b1;
						end
					end
				end
				PH_RESP: begin
					cnt_d = cnt_inc[9:0];
					if (cnt_inc >= {8'd0, req_rlen_q}) begin
						do_resp_done = 1'b1;
						rd_r1        = {7'd0, r1nz_q};
					end else begin
						emit         = 1'b1;
						r_host_valid = 1'b1;
						r_host_byte  = miso_byte;
					end
				end
				PH_TOKEN: begin
					if (miso_byte == DATA_TOKEN) begin
						phase_d = PH_DATA;
						cnt_d   = 10'd0;
					end
					emit = 1'b1;
				end
				PH_DATA: begin
					if (cnt_inc >= {1'b0, req_dlen_q}) begin
						phase_d = PH_CRC;
						cnt_d   = 10'd0;
					end else begin
						cnt_d = cnt_inc[9:0];
					end
					emit         = 1'b1;
					r_host_valid = 1'b1;
					r_host_kind  = 1'b1;
					r_host_byte  = miso_byte;
				end
				PH_CRC: begin
					cnt_d = cnt_inc[9:0];
					if (cnt_inc >= 11'd2) begin
						do_finish  = 1'b1;
						fin_status = ST_OK;
					end else begin
						emit = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end

		// response collected: prefix check, data wait or finish
		if (do_resp_done) begin
			r_host_valid = 1'b1;
			r_host_byte  = miso_byte;
			if (prefix_q) begin
				if (rd_r1[7:1] != 7'd0) begin
					do_finish  = 1'b1;
					fin_status = ST_APP_REJECT;
				end else begin
					prefix_d  = 1'b0;
					do_start  = 1'b1;
					start_cmd = req_cmd_q;
					start_arg = req_arg_q;
					emit      = 1'b1;
				end
			end else if (req_dlen_q != 10'd0) begin
				if (r1nz_d) begin
					do_finish  = 1'b1;
					fin_status = ST_R1_ERROR;
				end else begin
					phase_d = PH_TOKEN;
					cnt_d   = 10'd0;
					emit    = 1'b1;
				end
			end else begin
				do_finish  = 1'b1;
				fin_status = ST_OK;
			end
		end

		// command start: flush then frame
		if (do_start) begin
			frm_cmd_d = start_cmd;
			frm_arg_d = start_arg;
			cnt_d     = 10'd0;
			poll_d    = 8'd0;
			r1nz_d    = 1'b0;
			phase_d   = (FLUSH_BYTES != 10'd0) ? PH_FLUSH : PH_FRAME;
		end

		if (do_finish) begin
			phase_d  = PH_IDLE;
			cnt_d    = 10'd0;
			r_done   = 1'b1;
			r_status = fin_status;
		end

		// next byte on the bus
		if (emit) begin
			r_mosi_valid = 1'b1;
			r_mosi_byte  = IDLE_BYTE;
			if (phase_d == PH_FRAME) begin
				unique case (cnt_d[2:0])
					3'd0:    r_mosi_byte = {FRAME_START, frm_cmd_d};
					3'd1:    r_mosi_byte = frm_arg_d[31:24];
					3'd2:    r_mosi_byte = frm_arg_d[23:16];
					3'd3:    r_mosi_byte = frm_arg_d[15:8];
					3'd4:    r_mosi_byte = frm_arg_d[7:0];
					3'd5:    r_mosi_byte = {crc, 1'b1};
					default: r_mosi_byte = IDLE_BYTE;
				endcase
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			cnt_q        <= 10'd0;
			poll_q       <= 8'd0;
			prefix_q     <= 1'b0;
			r1nz_q       <= 1'b0;
			poll_limit_q <= POLL_LIMIT_RST;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				poll_limit_q <= cfg_wr_data;
			end
			if (in_fire) begin
				phase_q     <= phase_d;
				cnt_q       <= cnt_d;
				poll_q      <= poll_d;
				prefix_q    <= prefix_d;
				r1nz_q      <= r1nz_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request, frame and result payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_cmd_q    <= req_cmd_d;
			req_arg_q    <= req_arg_d;
			req_rlen_q   <= req_rlen_d;
			req_dlen_q   <= req_dlen_d;
			frm_cmd_q    <= frm_cmd_d;
			frm_arg_q    <= frm_arg_d;
			mosi_valid_q <= r_mosi_valid;
			mosi_byte_q  <= r_mosi_byte;
			host_valid_q <= r_host_valid;
			host_kind_q  <= r_host_kind;
			host_byte_q  <= r_host_byte;
			done_q       <= r_done;
			status_q     <= r_status;
		end
	end

	assign out_valid  = out_valid_q;
	assign mosi_valid = mosi_valid_q;
	assign mosi_byte  = mosi_byte_q;
	assign host_valid = host_valid_q;
	assign host_kind  = host_kind_q;
	assign host_byte  = host_byte_q;
	assign done_res   = done_q;
	assign status     = status_q;

endmodule

// ----- design/sdspi_crc7.sv -----
module sdspi_crc7 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [39:0] frame,
	output logic [6:0]  crc
);
	import sdspi_pkg::*;

	logic [6:0]  crc_q;
	logic [31:0] data_q;
	logic [2:0]  count_q;

	// first byte folds in at start, the other four one per cycle after
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 3'd0;
		end else if (start) begin
			count_q <= 3'd4;
		end else if (count_q != 3'd0) begin
			count_q <= count_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			crc_q  <= crc7_byte(7'd0, frame[39:32]);
			data_q <= frame[31:0];
		end else if (count_q != 3'd0) begin
			crc_q  <= crc7_byte(crc_q, data_q[31:24]);
			data_q <= {data_q[23:0], 8'd0};
		end
	end

	assign crc = crc_q;

endmodule

// ----- tb/sd_spi_command_engine_core_test.sv -----
module sd_spi_command_engine_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import sdspi_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 80;

	// one input word and one result word
	typedef struct packed {
		logic        mode;
		logic [5:0]  cmd;
		logic [31:0] arg;
		logic [2:0]  rlen;
		logic        app;
		logic [9:0]  dlen;
		logic [7:0]  miso;
	} bus_word_t;

	typedef struct packed {
		logic       mosi_v;
		logic [7:0] mosi_b;
		logic       host_v;
		logic       host_k;
		logic [7:0] host_b;
		logic       done;
		status_t    st;
	} reply_t;

	typedef enum logic [2:0] {
		PH_IDLE, PH_FLUSH, PH_FRAME, PH_POLL, PH_RESP, PH_TOKEN, PH_DATA, PH_CRC
	} engine_phase_t;

	typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_RUNS} stall_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [7:0]  cfg_wr_data = 8'h00;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        mode = 1'b0;
	logic [5:0]  cmd_index = 6'd0;
	logic [31:0] argument = 32'h0;
	logic [2:0]  resp_bytes = 3'd0;
	logic        app_prefix = 1'b0;
	logic [9:0]  data_len = 10'd0;
	logic [7:0]  miso_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        mosi_valid;
	logic [7:0]  mosi_byte;
	logic        host_valid;
	logic        host_kind;
	logic [7:0]  host_byte;
	logic        done_res;
	status_t     status;

	// expected results, oldest first
	reply_t pending_replies[$];

	// engine state as the predictor sees it
	engine_phase_t eng_phase = PH_IDLE;
	int            eng_count = 0;
	int            eng_polls = 0;
	logic [47:0]   frame_q = '0;
	logic [5:0]    cur_cmd = '0;
	logic [31:0]   cur_arg = '0;
	int            cur_rlen = 0;
	int            cur_dlen = 0;
	bit            app_pending = 1'b0;
	bit            r1_bad = 1'b0;
	logic [7:0]    poll_limit = POLL_LIMIT_RST;

	// traffic shaping and bookkeeping
	bit          gaps_on = 1'b1;
	int          burst_left = 0;
	stall_mode_t stall_mode = STALL_RANDOM;
	bit          hold_off_req = 1'b0;
	int          hold_left = 0;
	int          run_left = 0;
	bit          run_stalled = 1'b0;
	int          quiet_cycles = 0;
	int          mismatches = 0;
	int          words_sent = 0;
	int          results_checked = 0;
	int          transactions = 0;
	int          limit_writes = 0;
	int          status_seen[4] = '{0, 0, 0, 0};

	sd_spi_command_engine_core DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.cmd_index  (cmd_index),
		.argument   (argument),
		.resp_bytes (resp_bytes),
		.app_prefix (app_prefix),
		.data_len   (data_len),
		.miso_byte  (miso_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.mosi_valid (mosi_valid),
		.mosi_byte  (mosi_byte),
		.host_valid (host_valid),
		.host_kind  (host_kind),
		.host_byte  (host_byte),
		.done_res   (done_res),
		.status     (status)
	);

	always #5 clk = ~clk;

	// result word with unused fields forced to zero
	function automatic reply_t pack_reply(bit mv, logic [7:0] mb, bit hv, bit hk,
			logic [7:0] hb, bit dn, status_t st);
		reply_t r;
		r.mosi_v = mv;
		r.mosi_b = mv ? mb : 8'h00;
		r.host_v = hv;
		r.host_k = hv ? hk : 1'b0;
		r.host_b = hv ? hb : 8'h00;
		r.done   = dn;
		r.st     = dn ? st : ST_OK;
		return r;
	endfunction

	// ask for another exchange; frame bytes go out msb first
	function automatic reply_t keep_going(bit hv, bit hk, logic [7:0] hb);
		logic [7:0] tx;
		tx = IDLE_BYTE;
		if (eng_phase == PH_FRAME) begin
			tx = frame_q[8 * (5 - eng_count % 6) +: 8];
		end
		return pack_reply(1'b1, tx, hv, hk, hb, 1'b0, ST_OK);
	endfunction

	function automatic reply_t wrap_up(bit hv, logic [7:0] hb, status_t st);
		eng_phase = PH_IDLE;
		eng_count = 0;
		return pack_reply(1'b0, 8'h00, hv, 1'b0, hb, 1'b1, st);
	endfunction

	// build the 6-byte frame with its crc-7 and restart from the flush
	function automatic void load_frame(logic [5:0] cmd, logic [31:0] arg);
		logic [39:0] body;
		logic [6:0]  crc;
		bit          fb;
		body = {FRAME_START, cmd, arg};
		crc = '0;
		for (int i = 39; i >= 0; i--) begin
			fb  = crc[6] ^ body[i];
			crc = {crc[5:0], 1'b0};
			if (fb) begin
				crc = crc ^ CRC7_POLY;
			end
		end
		frame_q   = {body, crc, 1'b1};
		eng_count = 0;
		eng_polls = 0;
		r1_bad    = 1'b0;
		eng_phase = (FLUSH_BYTES > 0) ? PH_FLUSH : PH_FRAME;
	endfunction

	// last response byte in: go on with the command, the data, or stop
	function automatic reply_t response_done(logic [7:0] hb);
		if (app_pending) begin
			if (hb[7:1] != 7'd0) begin
				return wrap_up(1'b1, hb, ST_APP_REJECT);
			end
			app_pending = 1'b0;
			load_frame(cur_cmd, cur_arg);
			return keep_going(1'b1, 1'b0, hb);
		end
		if (cur_dlen > 0) begin
			if (r1_bad) begin
				return wrap_up(1'b1, hb, ST_R1_ERROR);
			end
			eng_phase = PH_TOKEN;
			eng_count = 0;
			return keep_going(1'b1, 1'b0, hb);
		end
		return wrap_up(1'b1, hb, ST_OK);
	endfunction

	// expected result for one accepted word
	function automatic reply_t next_bus_reply(input bus_word_t w);
		int need;
		if (!w.mode) begin
			cur_cmd  = w.cmd;
			cur_arg  = w.arg;
			cur_rlen = (w.rlen == 3'd0) ? 1 : ((w.rlen > 3'd5) ? 5 : int'(w.rlen));
			cur_dlen = (w.dlen > MAX_BLOCK_BYTES) ? int'(MAX_BLOCK_BYTES) : int'(w.dlen);
			app_pending = w.app;
			if (w.app) begin
				load_frame(APP_CMD_INDEX, 32'h0);
			end else begin
				load_frame(w.cmd, w.arg);
			end
			return keep_going(1'b0, 1'b0, 8'h00);
		end
		case (eng_phase)
			PH_FLUSH: begin
				eng_count++;
				if (eng_count >= int'(FLUSH_BYTES)) begin
					eng_phase = PH_FRAME;
					eng_count = 0;
				end
				return keep_going(1'b0, 1'b0, 8'h00);
			end
			PH_FRAME: begin
				eng_count++;
				if (eng_count >= 6) begin
					eng_phase = PH_POLL;
					eng_count = 0;
					eng_polls = 0;
				end
				return keep_going(1'b0, 1'b0, 8'h00);
			end
			PH_POLL: begin
				if (!w.miso[7]) begin
					r1_bad = (w.miso != 8'h00);
					need = app_pending ? 1 : cur_rlen;
					if (need > 1) begin
						eng_phase = PH_RESP;
						eng_count = 1;
						return keep_going(1'b1, 1'b0, w.miso);
					end
					return response_done(w.miso);
				end
				eng_polls++;
				if (eng_polls >= int'(poll_limit)) begin
					return wrap_up(1'b0, 8'h00, ST_TIMEOUT);
				end
				return keep_going(1'b0, 1'b0, 8'h00);
			end
			PH_RESP: begin
				eng_count++;
				if (eng_count >= cur_rlen) begin
					return response_done(w.miso);
				end
				return keep_going(1'b1, 1'b0, w.miso);
			end
			PH_TOKEN: begin
				if (w.miso == DATA_TOKEN) begin
					eng_phase = PH_DATA;
					eng_count = 0;
				end
				return keep_going(1'b0, 1'b0, 8'h00);
			end
			PH_DATA: begin
				eng_count++;
				if (eng_count >= cur_dlen) begin
					eng_phase = PH_CRC;
					eng_count = 0;
				end
				return keep_going(1'b1, 1'b1, w.miso);
			end
			PH_CRC: begin
				eng_count++;
				if (eng_count >= 2) begin
					return wrap_up(1'b0, 8'h00, ST_OK);
				end
				return keep_going(1'b0, 1'b0, 8'h00);
			end
			default: begin
				return pack_reply(1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, ST_OK);
			end
		endcase
	endfunction

	function automatic bus_word_t rand_word();
		bus_word_t w;
		w.mode = 1'($urandom_range(0, 1));
		w.cmd  = 6'($urandom_range(0, 63));
		w.arg  = $urandom;
		w.rlen = 3'($urandom_range(0, 7));
		w.app  = 1'($urandom_range(0, 1));
		w.dlen = 10'($urandom_range(0, 1023));
		w.miso = 8'($urandom_range(0, 255));
		return w;
	endfunction

	function automatic bus_word_t make_request(logic [5:0] cmd, logic [31:0] arg,
			logic [2:0] rlen, logic app, logic [9:0] dlen);
		bus_word_t w;
		w      = rand_word();
		w.mode = 1'b0;
		w.cmd  = cmd;
		w.arg  = arg;
		w.rlen = rlen;
		w.app  = app;
		w.dlen = dlen;
		return w;
	endfunction

	// offer one word in bursts with random gaps, predict it once taken
	task automatic send_word(input bus_word_t w);
		reply_t r;
		if (gaps_on && burst_left == 0) begin
			in_valid <= 1'b0;
			repeat (($urandom_range(0, 7) == 0) ? $urandom_range(8, 25) : $urandom_range(1, 5))
				@(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		if (burst_left > 0) begin
			burst_left--;
		end
		in_valid   <= 1'b1;
		mode       <= w.mode;
		cmd_index  <= w.cmd;
		argument   <= w.arg;
		resp_bytes <= w.rlen;
		app_prefix <= w.app;
		data_len   <= w.dlen;
		miso_byte  <= w.miso;
		do @(posedge clk); while (in_stall !== 1'b0);
		r = next_bus_reply(w);
		pending_replies.push_back(r);
		words_sent++;
	endtask

	task automatic send_idle_word(input logic [7:0] b);
		bus_word_t w;
		w      = rand_word();
		w.mode = 1'b1;
		w.miso = b;
		send_word(w);
	endtask

	// play the card side of one transaction; a nonzero cut leaves it unfinished
	task automatic play_transaction(input bus_word_t req, input int busy_polls,
			input logic [7:0] app_r1, input logic [7:0] main_r1,
			input int token_skips, input int cut_after);
		bus_word_t w;
		int        sent;
		int        polls_seen;
		int        skips;
		send_word(req);
		transactions++;
		sent       = 0;
		polls_seen = 0;
		skips      = 0;
		while (eng_phase != PH_IDLE && (cut_after == 0 || sent < cut_after)) begin
			w      = rand_word();
			w.mode = 1'b1;
			case (eng_phase)
				PH_FLUSH, PH_FRAME: begin
					polls_seen = 0;
				end
				PH_POLL: begin
					if (polls_seen < busy_polls) begin
						w.miso[7] = 1'b1;
						polls_seen++;
					end else begin
						w.miso = app_pending ? app_r1 : main_r1;
					end
				end
				PH_TOKEN: begin
					if (skips < token_skips) begin
						skips++;
						if (w.miso == DATA_TOKEN) begin
							w.miso = 8'h00;
						end
					end else begin
						w.miso = DATA_TOKEN;
					end
				end
				default: ;
			endcase
			send_word(w);
			sent++;
		end
	endtask

	// stop offering and let every expected word come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_replies.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic set_poll_limit(input logic [7:0] value);
		wait_drained();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en  <= 1'b0;
		poll_limit = value;
		limit_writes++;
	endtask

	// bytes from the card while nothing is running
	task automatic test_idle_words();
		send_idle_word(8'h00);
		send_idle_word(8'hFF);
		send_idle_word(8'($urandom_range(0, 255)));
	endtask

	// a command dropped in its flush; the next request takes over
	task automatic test_request_while_busy();
		play_transaction(make_request(6'd5, $urandom, 3'd1, 1'b0, 10'd0), 0, 8'h00, 8'h00, 0, 2);
	endtask

	// receiver holds off while the sender keeps offering words; top command fields,
	// saturated response length, token hunt and a short block
	task automatic test_backpressure();
		gaps_on      = 1'b0;
		stall_mode   = STALL_NONE;
		hold_off_req = 1'b1;
		play_transaction(make_request(6'd63, 32'hFFFF_FFFF, 3'd7, 1'b0, 10'd4),
			2, 8'h00, 8'h00, 2, 0);
		gaps_on    = 1'b1;
		stall_mode = STALL_RANDOM;
	endtask

	// cmd55 taken with idle r1 then a bad r1 ahead of an oversized block; cmd55 rejected
	task automatic test_app_prefix();
		stall_mode = STALL_RUNS;
		play_transaction(make_request(6'd17, 32'h0000_0200, 3'd0, 1'b1, 10'd1023),
			1, 8'h01, 8'h04, 0, 0);
		play_transaction(make_request(6'd41, 32'h4000_0000, 3'd3, 1'b1, 10'd0),
			0, 8'h7E, 8'h00, 0, 0);
		stall_mode = STALL_RANDOM;
	endtask

	// poll limit at zero times out on the first busy byte, then back at reset value
	task automatic test_poll_limits();
		set_poll_limit(8'd0);
		play_transaction(make_request(6'd1, 32'h0, 3'd6, 1'b0, 10'd0), 1, 8'h00, 8'h00, 0, 0);
		set_poll_limit(POLL_LIMIT_RST);
	endtask

	// receiver stall pattern and the long hold-off
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (hold_off_req) begin
			hold_off_req = 1'b0;
			hold_left    = HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			case (stall_mode)
				STALL_NONE: out_stall <= 1'b0;
				STALL_RANDOM: out_stall <= ($urandom_range(0, 3) == 0);
				default: begin
					if (run_left == 0) begin
						run_stalled = !run_stalled;
						run_left = run_stalled ? $urandom_range(1, 6) : $urandom_range(1, 12);
					end else begin
						run_left--;
					end
					out_stall <= run_stalled;
				end
			endcase
		end
	end

	function automatic void check_field(string what, logic [7:0] exp_v, logic [7:0] act_v);
		if (act_v !== exp_v) begin
			mismatches++;
			if (mismatches <= 100) begin
				$display("%0t: %s mismatch, expected %0h, got %0h", $time, what, exp_v, act_v);
			end
		end
	endfunction

	// compare each result word with the oldest expectation
	always @(posedge clk) begin
		reply_t want;
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
			results_checked++;
			if (pending_replies.size() == 0) begin
				mismatches++;
				$display("%0t: result word with nothing expected", $time);
			end else begin
				want = pending_replies.pop_front();
				check_field("mosi_valid", 8'(want.mosi_v), 8'(mosi_valid));
				check_field("mosi_byte", want.mosi_b, mosi_byte);
				check_field("host_valid", 8'(want.host_v), 8'(host_valid));
				check_field("host_kind", 8'(want.host_k), 8'(host_kind));
				check_field("host_byte", want.host_b, host_byte);
				check_field("done_res", 8'(want.done), 8'(done_res));
				check_field("status", 8'(want.st), 8'(status));
				if (done_res === 1'b1) begin
					status_seen[status]++;
				end
			end
		end
	end

	// end the run when no word moves for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no word moved for %0d cycles, %0d results outstanding",
				$time, QUIET_LIMIT, pending_replies.size());
			$display("sd_spi_command_engine_core_test NOT OK");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_words();
		test_request_while_busy();
		test_backpressure();
		test_app_prefix();
		test_poll_limits();
		wait_drained();
		$display("%0d words in %0d transactions, %0d results checked, %0d poll limit writes",
			words_sent, transactions, results_checked, limit_writes);
		$display("completions: %0d ok, %0d timeout, %0d app rejected, %0d r1 error",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
		if (mismatches == 0) begin
			$display("sd_spi_command_engine_core_test OK");
		end else begin
			$display("sd_spi_command_engine_core_test NOT OK");
		end
		$finish;
	end

endmodule

// ----- files.f -----
design/sdspi_pkg.sv
design/sdspi_crc7.sv
design/sd_spi_command_engine_core.sv
tb/sd_spi_command_engine_core_test.sv
